[sv/wss_pkg.sv]
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and fixed field widths of the weighted sample selector.
// ----------------------------------------------------------------------------
package wss_pkg;

	localparam int HANDLE_W  = 16;
	localparam int WEIGHT_W  = 16;
	localparam int RAND_W    = 16;
	localparam int TOTAL_W   = 24;
	localparam int IDX_OUT_W = 8;
	localparam int CNT_OUT_W = 9;
	localparam int PROD_W    = RAND_W + TOTAL_W;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_DRAW  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL   = 7'b0000010,
		S_SEL   = 7'b0000100,
		S_FETCH = 7'b0001000,
		S_TAKE  = 7'b0010000,
		S_WALK  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic pick_valid;
		logic table_full;
	} res_flags_t;

endpackage

[sv/wss_ram.sv]
// ----------------------------------------------------------------------------
// wss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[sv/wss_ctrl.sv]
// ----------------------------------------------------------------------------
// wss_ctrl
// Command sequencer: table bookkeeping, shared multiplier for the draw target,
// and the prefix-sum walk over the weight store, one entry per cycle.
// ----------------------------------------------------------------------------
module wss_ctrl import wss_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int WEIGHT_BITS = 16,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int WB    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [HANDLE_W-1:0] sample_handle,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                weighted_pick,
	input  logic [RAND_W-1:0]   random_word,
	input  logic                out_free,
	output logic                res_ready,
	output res_flags_t          res_flags,
	output logic [IDX_W-1:0]    res_idx,
	output logic [HANDLE_W-1:0] res_handle,
	output logic [CNT_W-1:0]    count,
	output logic [TOTAL_W-1:0]  total,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_addr,
	output logic [HANDLE_W-1:0] wr_handle,
	output logic [WB-1:0]       wr_weight,
	output logic [IDX_W-1:0]    rd_addr,
	input  logic [HANDLE_W-1:0] rd_handle,
	input  logic [WB-1:0]       rd_weight
);

	localparam int PFX_W = CNT_W + WB;
	localparam int CMP_W = (PFX_W > TOTAL_W) ? PFX_W : TOTAL_W;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] total_q;
	logic [RAND_W-1:0]  rnd_q;
	logic               weighted_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TOTAL_W-1:0] target_q;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [IDX_W-1:0]   chk_idx_q;
	logic               chk_q;
	logic [PFX_W-1:0]   prefix_q;
	res_flags_t         flags_q;
	logic [IDX_W-1:0]   idx_q;
	logic [HANDLE_W-1:0] handle_q;

	logic               accept;
	logic               is_full;
	logic [TOTAL_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_d;
	logic [PFX_W-1:0]   pfx_sum;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   last_idx;
	logic               hit;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign is_full  = (count_q >= CNT_W'(TABLE_DEPTH));

	assign wr_en     = accept && (cmd_t'(command) == CMD_ADD) && !is_full;
	assign wr_addr   = count_q[IDX_W-1:0];
	assign wr_handle = sample_handle;
	assign wr_weight = weight[WB-1:0];
	assign rd_addr   = rd_addr_q;

	// shared multiplier: r * total for a weighted draw, r * count for uniform
	assign mul_b  = weighted_q ? total_q : TOTAL_W'(count_q);
	assign prod_d = PROD_W'(rnd_q) * PROD_W'(mul_b);

	assign pfx_sum  = prefix_q + PFX_W'(rd_weight);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];
	// all-zero weights run off the end; the last entry catches that
	assign hit = chk_q && ((CMP_W'(pfx_sum) > CMP_W'(target_q)) || (chk_idx_q == last_idx));

	assign res_ready  = (state_q == S_FIN) && out_free;
	assign res_flags  = flags_q;
	assign res_idx    = idx_q;
	assign res_handle = handle_q;
	assign count      = count_q;
	assign total      = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			chk_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						unique case (cmd_t'(command))
							CMD_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							CMD_ADD: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
									total_q <= total_q + TOTAL_W'(weight[WB-1:0]);
								end
							end
							CMD_DRAW: begin
								if (count_q == CNT_W'(1)) begin
									state_q <= S_FETCH;
								end else if (count_q != '0) begin
									state_q <= S_MUL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MUL:   state_q <= S_SEL;
				S_SEL: begin
					chk_q   <= 1'b0;
					state_q <= weighted_q ? S_WALK : S_FETCH;
				end
				S_FETCH: state_q <= S_TAKE;
				S_TAKE:  state_q <= S_FIN;
				S_WALK: begin
					chk_q <= 1'b1;
					if (hit) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rnd_q              <= random_word;
				weighted_q         <= weighted_pick;
				rd_addr_q          <= '0;
				flags_q.pick_valid <= (cmd_t'(command) == CMD_DRAW) && (count_q != '0);
				flags_q.table_full <= (cmd_t'(command) == CMD_ADD) && is_full;
				idx_q              <= '0;
				handle_q           <= '0;
			end
			S_MUL: prod_q <= prod_d;
			S_SEL: begin
				target_q  <= prod_q[PROD_W-1 -: TOTAL_W];
				prefix_q  <= '0;
				rd_addr_q <= weighted_q ? '0 : prod_q[RAND_W +: IDX_W];
			end
			S_TAKE: begin
				idx_q    <= rd_addr_q;
				handle_q <= rd_handle;
			end
			S_WALK: begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
				chk_idx_q <= rd_addr_q;
				if (chk_q) begin
					prefix_q <= pfx_sum;
				end
				if (hit) begin
					idx_q    <= chk_idx_q;
					handle_q <= rd_handle;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/weighted_sample_selector_top.sv]
// ----------------------------------------------------------------------------
// weighted_sample_selector_top
// Table of weighted samples with uniform or roulette-wheel draw.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | command, sample_handle, weight,
//          |     |                    | weighted_pick, random_word
//  out     | out | out_valid/out_stall| pick_valid, picked_index, picked_handle,
//          |     |                    | entry_count, weight_total, table_full
//
//  An empty or one-entry draw skips the multiplier; a uniform draw scales
//  r by the count to pick the entry; a weighted draw instead walks the prefix
//  sums, reading one weight per cycle, until the sum passes r * total.
//  Reset clears the count and running total; the stores need no clearing.
//  The input stalls while a beat is in work; a result waits in the output
//  register without blocking the next input beat.
// ----------------------------------------------------------------------------
module weighted_sample_selector_top import wss_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [HANDLE_W-1:0]  sample_handle,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic                 weighted_pick,
	input  logic [RAND_W-1:0]    random_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 pick_valid,
	output logic [IDX_OUT_W-1:0] picked_index,
	output logic [HANDLE_W-1:0]  picked_handle,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [TOTAL_W-1:0]   weight_total,
	output logic                 table_full
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int WB    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

	logic                out_free;
	logic                res_ready;
	res_flags_t          res_flags;
	logic [IDX_W-1:0]    res_idx;
	logic [HANDLE_W-1:0] res_handle;
	logic [CNT_W-1:0]    count;
	logic [TOTAL_W-1:0]  total;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [HANDLE_W-1:0] wr_handle;
	logic [WB-1:0]       wr_weight;
	logic [IDX_W-1:0]    rd_addr;
	logic [HANDLE_W-1:0] rd_handle;
	logic [WB-1:0]       rd_weight;

	logic                 out_valid_q;
	logic                 pick_valid_q;
	logic [IDX_OUT_W-1:0] picked_index_q;
	logic [HANDLE_W-1:0]  picked_handle_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	logic [TOTAL_W-1:0]   weight_total_q;
	logic                 table_full_q;

	wss_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.sample_handle (sample_handle),
		.weight        (weight),
		.weighted_pick (weighted_pick),
		.random_word   (random_word),
		.out_free      (out_free),
		.res_ready     (res_ready),
		.res_flags     (res_flags),
		.res_idx       (res_idx),
		.res_handle    (res_handle),
		.count         (count),
		.total         (total),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_handle     (wr_handle),
		.wr_weight     (wr_weight),
		.rd_addr       (rd_addr),
		.rd_handle     (rd_handle),
		.rd_weight     (rd_weight)
	);

	wss_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (TABLE_DEPTH)
	) u_handle_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_handle),
		.rd_addr (rd_addr),
		.rd_data (rd_handle)
	);

	wss_ram #(
		.WIDTH (WB),
		.DEPTH (TABLE_DEPTH)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_weight),
		.rd_addr (rd_addr),
		.rd_data (rd_weight)
	);

	// output register: free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			pick_valid_q    <= res_flags.pick_valid;
			picked_index_q  <= IDX_OUT_W'(res_idx);
			picked_handle_q <= res_handle;
			entry_count_q   <= CNT_OUT_W'(count);
			weight_total_q  <= total;
			table_full_q    <= res_flags.table_full;
		end
	end

	assign out_valid     = out_valid_q;
	assign pick_valid    = pick_valid_q;
	assign picked_index  = picked_index_q;
	assign picked_handle = picked_handle_q;
	assign entry_count   = entry_count_q;
	assign weight_total  = weight_total_q;
	assign table_full    = table_full_q;

endmodule
